/* rtl/ucd_pkg.sv */
// Shared constants and types for the UTF-8 code point decoder.
package ucd_pkg;

  // Word widths.
  localparam int BYTE_W = 8;
  localparam int CP_W   = 21;
  localparam int CONT_W = 6;
  localparam int LEAD_W = 7;
  localparam int MORE_W = 2;

  // Lead byte masks and tags.
  localparam logic [BYTE_W-1:0] ASCII_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] ASCII_TAG  = 8'h00;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD2_TAG  = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD3_TAG  = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'hF8;
  localparam logic [BYTE_W-1:0] LEAD4_TAG  = 8'hF0;
  localparam logic [BYTE_W-1:0] LEAD2_BITS = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_BITS = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_BITS = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_BITS  = 8'h3F;

  // Continuation counts set by a lead byte.
  localparam logic [MORE_W-1:0] MORE_NONE = 2'd0;
  localparam logic [MORE_W-1:0] MORE_ONE  = 2'd1;
  localparam logic [MORE_W-1:0] MORE_TWO  = 2'd2;
  localparam logic [MORE_W-1:0] MORE_THREE = 2'd3;

  // Queue between the classifier and the sequence builder.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified byte: its meaning as a lead byte and as a continuation byte.
  typedef struct packed {
    logic [MORE_W-1:0] more;
    logic [LEAD_W-1:0] lead_bits;
    logic [CONT_W-1:0] cont_bits;
    logic              eos;
  } tok_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

/* rtl/ucd_if.sv */
// Byte and code point channel interfaces.
interface ucd_byte_if;
  logic                       valid;
  logic                       ready;
  logic [ucd_pkg::BYTE_W-1:0] data_byte;
  logic                       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface ucd_cp_if;
  logic                     valid;
  logic                     ready;
  logic [ucd_pkg::CP_W-1:0] code_point;
  logic                     last_of_string;

  modport source (output valid, output code_point, output last_of_string, input ready);
  modport sink (input valid, input code_point, input last_of_string, output ready);
endinterface

/* rtl/ucd_front.sv */
// Front end: accepts bytes and classifies each one for the sequence builder.
module ucd_front (
  ucd_byte_if.sink       in_ch,
  input  ucd_pkg::qstat_t qstat,
  output logic           push,
  output ucd_pkg::tok_t  tok
);
  import ucd_pkg::*;

  // A word is taken whenever the queue has room.
  assign in_ch.ready = !qstat.full;
  assign push        = in_ch.valid && !qstat.full;

  // Decode the byte as a lead byte; an invalid lead gives zero bits and no tail.
  always_comb begin
    tok.eos       = in_ch.end_of_string;
    tok.cont_bits = CONT_W'(in_ch.data_byte & CONT_BITS);
    if ((in_ch.data_byte & ASCII_MASK) == ASCII_TAG) begin
      tok.more      = MORE_NONE;
      tok.lead_bits = LEAD_W'(in_ch.data_byte);
    end else if ((in_ch.data_byte & LEAD2_MASK) == LEAD2_TAG) begin
      tok.more      = MORE_ONE;
      tok.lead_bits = LEAD_W'(in_ch.data_byte & LEAD2_BITS);
    end else if ((in_ch.data_byte & LEAD3_MASK) == LEAD3_TAG) begin
      tok.more      = MORE_TWO;
      tok.lead_bits = LEAD_W'(in_ch.data_byte & LEAD3_BITS);
    end else if ((in_ch.data_byte & LEAD4_MASK) == LEAD4_TAG) begin
      tok.more      = MORE_THREE;
      tok.lead_bits = LEAD_W'(in_ch.data_byte & LEAD4_BITS);
    end else begin
      tok.more      = MORE_NONE;
      tok.lead_bits = '0;
    end
  end

endmodule

/* rtl/ucd_queue.sv */
// Short queue of classified bytes between the front and back ends.
module ucd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ucd_pkg::tok_t   push_tok,
  input  logic            pop,
  output ucd_pkg::tok_t   head_tok,
  output ucd_pkg::qstat_t qstat
);
  import ucd_pkg::*;

  tok_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == QCNT_W'(QDEPTH));
  assign head_tok    = entry_r[rd_ptr_r];

  // Pointer and occupancy update; pointers wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

/* rtl/ucd_back.sv */
// Back end: builds code points from classified bytes and holds the output word.
module ucd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  ucd_pkg::tok_t   tok,
  input  ucd_pkg::qstat_t qstat,
  output logic            pop,
  ucd_cp_if.source        out_ch
);
  import ucd_pkg::*;

  logic [MORE_W-1:0] rem_r, rem_nxt;
  logic [CP_W-1:0]   part_r, part_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CP_W-1:0]   out_cp_r;
  logic              out_last_r;
  logic              emit;
  logic [CP_W-1:0]   emit_cp;
  logic [CP_W-1:0]   shifted;
  logic [MORE_W-1:0] rem_dec;

  // A byte is consumed when the output register is free or being emptied.
  assign pop = !qstat.empty && (!out_valid_r || out_ch.ready);

  assign shifted = {part_r[CP_W-CONT_W-1:0], tok.cont_bits};
  assign rem_dec = rem_r - MORE_W'(1);

  // Sequence state update for one consumed byte.
  always_comb begin
    rem_nxt  = rem_r;
    part_nxt = part_r;
    emit     = 1'b0;
    emit_cp  = shifted;
    if (pop) begin
      if (rem_r == MORE_NONE) begin
        emit_cp = CP_W'(tok.lead_bits);
        if (tok.more == MORE_NONE || tok.eos) begin
          emit     = 1'b1;
          rem_nxt  = MORE_NONE;
          part_nxt = '0;
        end else begin
          rem_nxt  = tok.more;
          part_nxt = CP_W'(tok.lead_bits);
        end
      end else if (rem_dec == MORE_NONE || tok.eos) begin
        emit     = 1'b1;
        rem_nxt  = MORE_NONE;
        part_nxt = '0;
      end else begin
        rem_nxt  = rem_dec;
        part_nxt = shifted;
      end
    end
  end

  // The output word stays until taken; a new result only lands when it is free.
  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= MORE_NONE;
      part_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      rem_r       <= rem_nxt;
      part_r      <= part_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_cp_r   <= emit_cp;
      out_last_r <= tok.eos;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.code_point     = out_cp_r;
  assign out_ch.last_of_string = out_last_r;

endmodule

/* rtl/utf8_codepoint_decoder_unit.sv */
// UTF-8 decoder: one byte word in, at most one code point word out per byte.
// A byte passes through a queue entry, then the output register, before its code point is valid.
// Throughput: one byte per cycle while the output is not stalled, set by the sequence update in the back end.
// A 2-entry queue lets the classifier keep taking bytes while the output is stalled.
// Synchronous active-low reset empties the queue, clears the sequence state and drops out valid.
module utf8_codepoint_decoder_unit (
  input  logic     clk,
  input  logic     rst_n,
  ucd_byte_if.sink in_ch,
  ucd_cp_if.source out_ch
);
  import ucd_pkg::*;

  logic   push;
  logic   pop;
  tok_t   push_tok;
  tok_t   head_tok;
  qstat_t qstat;

  // Classify incoming bytes.
  ucd_front u_front (
    .in_ch (in_ch),
    .qstat (qstat),
    .push  (push),
    .tok   (push_tok)
  );

  // Decouple the two ends.
  ucd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head_tok (head_tok),
    .qstat    (qstat)
  );

  // Build code points and drive the output word.
  ucd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .tok    (head_tok),
    .qstat  (qstat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* rtl/ucd_checker.sv */
// Port-level checks for the UTF-8 decoder, bound to the top level.
module ucd_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     in_eos,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [ucd_pkg::CP_W-1:0] out_cp,
  input logic                     out_last
);
  import ucd_pkg::*;

  // Strings whose final code point has not yet been delivered.
  logic [2:0] open_r, open_nxt;
  logic       in_end;
  logic       out_end;

  assign in_end  = in_valid && in_ready && in_eos;
  assign out_end = out_valid && out_ready && out_last;

  always_comb begin
    open_nxt = open_r;
    if (in_end && !out_end) begin
      open_nxt = open_r + 3'd1;
    end else if (out_end && !in_end) begin
      open_nxt = open_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_nxt;
    end
  end

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cp) && $stable(out_last))
    else $error("output word changed while stalled");

  // Reset drops the output.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A string end is only reported after an ending byte was taken.
  a_end_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> open_r != 3'd0)
    else $error("string end reported without an ending byte");

  // No more string ends in flight than queue entries plus the output word.
  a_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
    open_r <= 3'(QDEPTH + 1))
    else $error("string end lost inside the decoder");

endmodule

bind utf8_codepoint_decoder_unit ucd_checker u_ucd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_eos    (in_ch.end_of_string),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_cp    (out_ch.code_point),
  .out_last  (out_ch.last_of_string)
);
